// ===== rtl/core/cfr_pkg.sv =====
// Shared constants, codes and types of the clock frame replacement unit.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int FRAMES     = 64;
  localparam int OWNER_BITS = 8;
  localparam int IDX_W      = $clog2(FRAMES);

  localparam int OP_W     = 3;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  // stream payload widths; the tdata widths are rounded up to whole bytes
  localparam int IN_DATA_BITS  = IDX_W + OWNER_BITS + 2;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IN_USER_W     = OP_W + KIND_W;
  localparam int OUT_DATA_BITS = IDX_W + OWNER_BITS;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W    = STATUS_W + KIND_W;

  // operations
  localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE       = 3'd1;
  localparam logic [OP_W-1:0] OP_TOUCH        = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP         = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_OWNER = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SECOND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWAPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_KEPT    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOFRAME = 3'd6;

  // page kinds
  localparam logic [KIND_W-1:0] KIND_BIN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ANON = 2'd2;

  // one frame table entry as stored in the entry RAM
  typedef struct packed {
    logic                  accessed;
    logic                  dirty;
    logic [KIND_W-1:0]     kind;
    logic [OWNER_BITS-1:0] owner;
  } cfr_entry_t;

  localparam int ENTRY_W = $bits(cfr_entry_t);

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                insert;
    logic                remove;
    logic                touch_rd;
    logic                touch_wr;
    logic                scan_init;
    logic                sweep_init;
    logic                scan_adv;
    logic                ptr_rd;
    logic                step_commit;
    logic                sweep_chk;
    logic                result;
    logic                res_step;
    logic [STATUS_W-1:0] res_status;
  } cfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_ok;
    logic            target_ok;
    logic            ptr_in_use;
    logic            cnt_last;
  } cfr_stat_t;

endpackage

// ===== rtl/core/clock_frame_replacement_unit.sv =====
// Top level of the clock (second chance) frame replacement unit.
`timescale 1ns / 1ps

// The unit keeps a table of FRAMES physical frames and answers every input
// item with exactly one result item. Opcodes: insert a frame, remove a frame,
// touch a frame (access, optionally write), take one clock step, and remove
// every frame of one owner. A clock step walks from the frame after the hand
// in index order, wrapping, to the next frame in use: an accessed frame gets
// its accessed bit cleared (second chance), otherwise kind and dirtiness
// decide between dropped, swapped out, written back, or kept when swap is
// full. Items are taken one at a time. After an item is accepted:
//   insert, remove, unknown opcode: the execute state writes the result register
//   touch: entry RAM read, then write back
//   clock step: the scan skips free frames until a frame in use is found,
//     then reads its entry and evaluates it; the scan examines one frame per
//     cycle and reports no frame when no frame is in use
//   remove all of owner: the sweep reads each entry through the single read
//     port of the entry RAM, then checks it in a separate state
// A new item is accepted no earlier than the cycle after a result is
// produced, and only in a cycle where that result is taken by out_tready or
// has already left. Per-frame in-use marks are flip-flops
// cleared by reset; accessed, dirty, kind and owner live in the entry RAM and
// are always rewritten by insert before a frame is in use, so no clearing
// pass is needed after reset.

module clock_frame_replacement_unit
  import cfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [IDX_W-1:0] frame_index, then owner_id, is_write, swap_full; zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] opcode, [4:3] page_kind
  input  logic [IN_USER_W-1:0]  in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [IDX_W-1:0] victim_frame, then victim_owner; zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [2:0] status, [4:3] victim_kind
  output logic [OUT_USER_W-1:0] out_tuser
);

  cfr_cmd_t  cmd;
  cfr_stat_t stat;

  logic [OP_W-1:0]       opcode;
  logic [IDX_W-1:0]      frame_index;
  logic [OWNER_BITS-1:0] owner_id;
  logic [KIND_W-1:0]     page_kind;
  logic                  is_write;
  logic                  swap_full;

  logic [STATUS_W-1:0]   status;
  logic [IDX_W-1:0]      victim_frame;
  logic [OWNER_BITS-1:0] victim_owner;
  logic [KIND_W-1:0]     victim_kind;

  // unpack the input item
  assign opcode      = in_tuser[OP_W-1:0];
  assign page_kind   = in_tuser[OP_W +: KIND_W];
  assign frame_index = in_tdata[IDX_W-1:0];
  assign owner_id    = in_tdata[IDX_W +: OWNER_BITS];
  assign is_write    = in_tdata[IDX_W + OWNER_BITS];
  assign swap_full   = in_tdata[IDX_W + OWNER_BITS + 1];

  // pack the result item
  assign out_tuser = {victim_kind, status};
  assign out_tdata = OUT_DATA_W'({victim_owner, victim_frame});

  cfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cfr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .frame_index  (frame_index),
    .owner_id     (owner_id),
    .page_kind    (page_kind),
    .is_write     (is_write),
    .swap_full    (swap_full),
    .status       (status),
    .victim_frame (victim_frame),
    .victim_owner (victim_owner),
    .victim_kind  (victim_kind)
  );

`ifndef SYNTHESIS
  // accept only when the result register is free or being drained
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input accepted while result register is blocked");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in work");

  // results with status done or no frame carry zero victim fields
  a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((status == ST_DONE) || (status == ST_NOFRAME)))
      |-> ((victim_frame == '0) && (victim_owner == '0) && (victim_kind == '0)))
    else $error("victim fields set on a result without a victim");
`endif

endmodule

// ===== rtl/core/cfr_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cfr_ctrl.sv =====
// Controller state machine: sequences each operation and owns the result handshake.
`timescale 1ns / 1ps

module cfr_ctrl
  import cfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  cfr_stat_t stat,
  output cfr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_TOUCH     = 3'd2;
  localparam logic [2:0] S_SCAN      = 3'd3;
  localparam logic [2:0] S_EVAL      = 3'd4;
  localparam logic [2:0] S_SWEEP_RD  = 3'd5;
  localparam logic [2:0] S_SWEEP_CHK = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_INSERT: begin
            cmd.insert     = stat.idx_ok;
            cmd.result     = 1'b1;
            cmd.res_status = stat.idx_ok ? ST_DONE : ST_NOFRAME;
            state_nxt      = S_IDLE;
          end
          OP_REMOVE: begin
            cmd.remove     = stat.target_ok;
            cmd.result     = 1'b1;
            cmd.res_status = stat.target_ok ? ST_DONE : ST_NOFRAME;
            state_nxt      = S_IDLE;
          end
          OP_TOUCH: begin
            if (stat.target_ok) begin
              cmd.touch_rd = 1'b1;
              state_nxt    = S_TOUCH;
            end else begin
              cmd.result     = 1'b1;
              cmd.res_status = ST_NOFRAME;
              state_nxt      = S_IDLE;
            end
          end
          OP_STEP: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          OP_REMOVE_OWNER: begin
            cmd.sweep_init = 1'b1;
            state_nxt      = S_SWEEP_RD;
          end
          default: begin
            cmd.result     = 1'b1;
            cmd.res_status = ST_DONE;
            state_nxt      = S_IDLE;
          end
        endcase
      end
      S_TOUCH: begin
        cmd.touch_wr   = 1'b1;
        cmd.result     = 1'b1;
        cmd.res_status = ST_DONE;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        if (stat.ptr_in_use) begin
          cmd.ptr_rd = 1'b1;
          state_nxt  = S_EVAL;
        end else if (stat.cnt_last) begin
          cmd.result     = 1'b1;
          cmd.res_status = ST_NOFRAME;
          state_nxt      = S_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_EVAL: begin
        cmd.step_commit = 1'b1;
        cmd.result      = 1'b1;
        cmd.res_step    = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_SWEEP_RD: begin
        cmd.ptr_rd = 1'b1;
        state_nxt  = S_SWEEP_CHK;
      end
      S_SWEEP_CHK: begin
        cmd.sweep_chk = 1'b1;
        if (stat.cnt_last) begin
          cmd.result     = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SWEEP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // results are issued only while the output register is empty
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/cfr_dp.sv =====
// Datapath: frame table, clock hand, scan pointer and result register.
`timescale 1ns / 1ps

module cfr_dp
  import cfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfr_cmd_t              cmd,
  output cfr_stat_t             stat,
  input  logic [OP_W-1:0]       opcode,
  input  logic [IDX_W-1:0]      frame_index,
  input  logic [OWNER_BITS-1:0] owner_id,
  input  logic [KIND_W-1:0]     page_kind,
  input  logic                  is_write,
  input  logic                  swap_full,
  output logic [STATUS_W-1:0]   status,
  output logic [IDX_W-1:0]      victim_frame,
  output logic [OWNER_BITS-1:0] victim_owner,
  output logic [KIND_W-1:0]     victim_kind
);

  // captured item
  logic [OP_W-1:0]       op_r;
  logic [IDX_W-1:0]      idx_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [KIND_W-1:0]     kind_r;
  logic                  wr_r;
  logic                  sfull_r;

  // frame table state
  logic [FRAMES-1:0] in_use_r, in_use_nxt;
  logic [IDX_W-1:0]  hand_r, hand_nxt;
  logic              hand_valid_r, hand_valid_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;

  // result register
  logic [STATUS_W-1:0]   status_r;
  logic [IDX_W-1:0]      vframe_r;
  logic [OWNER_BITS-1:0] vowner_r;
  logic [KIND_W-1:0]     vkind_r;

  // entry RAM
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  cfr_entry_t       ram_wdata, ent;
  logic [ENTRY_W-1:0] ram_rdata;

  logic                idx_ok;
  logic [IDX_W-1:0]    scan_start;
  logic [IDX_W-1:0]    ptr_inc;
  logic [KIND_W-1:0]   kind_ins;
  logic [STATUS_W-1:0] step_status;
  logic                step_evict;
  logic                step_wb;
  logic                owner_hit;

  assign ent    = cfr_entry_t'(ram_rdata);
  assign idx_ok = ({1'b0, idx_r} < (IDX_W + 1)'(FRAMES));

  assign ptr_inc    = (ptr_r == IDX_W'(FRAMES - 1)) ? '0 : ptr_r + 1'b1;
  assign scan_start = !hand_valid_r ? '0 :
                      (hand_r == IDX_W'(FRAMES - 1)) ? '0 : hand_r + 1'b1;
  assign kind_ins   = (kind_r > KIND_ANON) ? KIND_ANON : kind_r;
  assign owner_hit  = in_use_r[ptr_r] && (ent.owner == owner_r);

  assign stat.op         = op_r;
  assign stat.idx_ok     = idx_ok;
  assign stat.target_ok  = idx_ok && in_use_r[idx_r];
  assign stat.ptr_in_use = in_use_r[ptr_r];
  assign stat.cnt_last   = (cnt_r == IDX_W'(FRAMES - 1));

  // victim decision for the frame under the hand
  always_comb begin
    step_status = ST_SWAPPED;
    step_evict  = 1'b1;
    step_wb     = 1'b0;
    if (ent.accessed) begin
      step_status = ST_SECOND;
      step_evict  = 1'b0;
      step_wb     = 1'b1;
    end else if (ent.kind == KIND_FILE) begin
      step_status = ent.dirty ? ST_WRITTEN : ST_DROPPED;
    end else if ((ent.kind == KIND_BIN) && !ent.dirty) begin
      step_status = ST_DROPPED;
    end else if (sfull_r) begin
      step_status = ST_KEPT;
      step_evict  = 1'b0;
    end
  end

  // entry RAM write and read ports
  always_comb begin
    ram_we    = cmd.insert || cmd.touch_wr || (cmd.step_commit && step_wb);
    ram_waddr = cmd.step_commit ? ptr_r : idx_r;
    ram_wdata = ent;
    if (cmd.insert) begin
      ram_wdata = '{accessed: 1'b0, dirty: 1'b0, kind: kind_ins, owner: owner_r};
    end else if (cmd.touch_wr) begin
      ram_wdata.accessed = 1'b1;
      ram_wdata.dirty    = ent.dirty | wr_r;
    end else begin
      ram_wdata.accessed = 1'b0;
    end
    ram_re    = cmd.touch_rd || cmd.ptr_rd;
    ram_raddr = cmd.touch_rd ? idx_r : ptr_r;
  end

  // table flags, hand and scan pointer
  always_comb begin
    in_use_nxt     = in_use_r;
    hand_nxt       = hand_r;
    hand_valid_nxt = hand_valid_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    if (cmd.insert) begin
      in_use_nxt[idx_r] = 1'b1;
    end
    if (cmd.remove) begin
      in_use_nxt[idx_r] = 1'b0;
    end
    if (cmd.step_commit) begin
      hand_nxt       = ptr_r;
      hand_valid_nxt = 1'b1;
      if (step_evict) begin
        in_use_nxt[ptr_r] = 1'b0;
      end
    end
    if (cmd.sweep_chk && owner_hit) begin
      in_use_nxt[ptr_r] = 1'b0;
    end
    if (cmd.scan_init) begin
      ptr_nxt = scan_start;
      cnt_nxt = '0;
    end else if (cmd.sweep_init) begin
      ptr_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.scan_adv) begin
      ptr_nxt = ptr_inc;
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r     <= '0;
      hand_r       <= '0;
      hand_valid_r <= 1'b0;
      ptr_r        <= '0;
      cnt_r        <= '0;
    end else begin
      in_use_r     <= in_use_nxt;
      hand_r       <= hand_nxt;
      hand_valid_r <= hand_valid_nxt;
      ptr_r        <= ptr_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode;
      idx_r   <= frame_index;
      owner_r <= owner_id;
      kind_r  <= page_kind;
      wr_r    <= is_write;
      sfull_r <= swap_full;
    end
    if (cmd.result) begin
      if (cmd.res_step) begin
        status_r <= step_status;
        vframe_r <= ptr_r;
        vowner_r <= ent.owner;
        vkind_r  <= ent.kind;
      end else begin
        status_r <= cmd.res_status;
        vframe_r <= '0;
        vowner_r <= '0;
        vkind_r  <= '0;
      end
    end
  end

  assign status       = status_r;
  assign victim_frame = vframe_r;
  assign victim_owner = vowner_r;
  assign victim_kind  = vkind_r;

  cfr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
